// File: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: action and status codes,
// and the command and result beats as packed structs.
// ----------------------------------------------------------------------------
package deq_pkg;

  // action codes
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
  localparam logic [2:0] ACT_POP_BACK   = 3'd1;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd2;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [2:0] ACT_READ       = 3'd4;
  localparam logic [2:0] ACT_RESIZE     = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_RESIZE = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [3:0]         index;
    logic [4:0]         new_size;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic signed [31:0] read_value;
    logic [4:0]         count;
    logic [1:0]         status;
  } out_item_t;

endpackage

// File: sv/deq_slot.sv
// ----------------------------------------------------------------------------
// deq_slot
// Shared address unit: maps an offset from the head pointer onto a physical
// slot of the ring, (base + offset) modulo DEPTH, with one compare and subtract.
// ----------------------------------------------------------------------------
module deq_slot #(
  parameter int DEPTH = 16
) (
  input  logic [$clog2(DEPTH)-1:0] base,
  input  logic [$clog2(DEPTH)-1:0] offset,
  output logic [$clog2(DEPTH)-1:0] slot
);

  localparam int PW = $clog2(DEPTH);

  logic [PW:0] sum;
  logic [PW:0] wrapped;

  // add, then fold back once: both operands stay below DEPTH
  assign sum     = {1'b0, base} + {1'b0, offset};
  assign wrapped = (sum >= (PW+1)'(DEPTH)) ? sum - (PW+1)'(DEPTH) : sum;
  assign slot    = wrapped[PW-1:0];

endmodule

// File: sv/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Ring store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WORD_WIDTH-1:0]    wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WORD_WIDTH-1:0]    rd_data
);

  logic [WORD_WIDTH-1:0] mem_r [DEPTH];
  logic [WORD_WIDTH-1:0] rd_data_r;

  // write on request, read every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed words kept as a ring in a memory.
// A small sequencer drives one shared slot-address unit and the ring RAM.
// ----------------------------------------------------------------------------
//  channel | ports                     | beat taken when
//  --------+---------------------------+---------------------------------
//  command | start, busy, in_item      | start high and busy low
//  result  | out_valid, out_item       | out_valid high (one cycle)
//
//  Push, pop, read and shrinking resize: busy through EXEC, RD_FRONT, RD_BACK
//  and FINISH after the command beat; the result strobes in the cycle after,
//  when a new command may enter, so commands do not overlap. The single RAM read
//  port sets this: the front and the back entry are fetched one after the other.
//  A growing resize adds a read state then a write state for each new entry.
//  Reset clears the head pointer and count; the RAM needs no clearing pass.
//  The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  deq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output deq_pkg::out_item_t out_item
);

  import deq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GROW_RD,
    S_GROW_WR,
    S_RD_FRONT,
    S_RD_BACK,
    S_FINISH
  } state_t;

  state_t    state_r;
  in_item_t  item_r;
  out_item_t out_item_r;
  logic      out_valid_r;

  logic [PW-1:0] head_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] nsz_r;
  logic [CW-1:0] i_r;
  logic [PW-1:0] j_r;
  logic [1:0]    status_r;
  logic          read_hit_r;
  logic [31:0]   read_r;
  logic [31:0]   front_r;

  logic [PW-1:0]         slot_off;
  logic [PW-1:0]         slot;
  logic                  ram_we;
  logic [WORD_WIDTH-1:0] ram_wdata;
  logic [WORD_WIDTH-1:0] ram_q;

  logic signed [63:0]    val_ext;
  logic [WORD_WIDTH-1:0] word_in;
  logic signed [63:0]    q_ext;
  logic [31:0]           word_out;

  logic          full;
  logic          idx_ok;
  logic          nsz_over;
  logic          grow_refused;
  logic          resize_ok;
  logic [CW-1:0] nsz_c;
  logic [XW-1:0] cnt_x;

  // shared slot unit, always relative to the head pointer
  deq_slot #(
    .DEPTH (DEPTH)
  ) u_slot (
    .base   (head_r),
    .offset (slot_off),
    .slot   (slot)
  );

  deq_ram #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (slot),
    .wr_data (ram_wdata),
    .rd_addr (slot),
    .rd_data (ram_q)
  );

  // size words between the 32-bit ports and the stored width
  assign val_ext  = 64'(item_r.value);
  assign word_in  = val_ext[WORD_WIDTH-1:0];
  assign q_ext    = 64'(signed'(ram_q));
  assign word_out = q_ext[31:0];

  // decode the held command
  assign full         = (cnt_r == CW'(DEPTH));
  assign idx_ok       = (XW'(item_r.index) < XW'(cnt_r));
  assign nsz_over     = (32'(item_r.new_size) > 32'(DEPTH));
  assign grow_refused = (cnt_r == '0) && (XW'(item_r.new_size) > XW'(cnt_r));
  assign resize_ok    = !nsz_over && !grow_refused;
  assign nsz_c        = CW'(item_r.new_size);
  assign cnt_x        = XW'(cnt_r);

  // steer the slot unit and the RAM write port
  always_comb begin
    slot_off  = '0;
    ram_we    = 1'b0;
    ram_wdata = (state_r == S_GROW_WR) ? ram_q : word_in;
    case (state_r)
      S_EXEC: begin
        case (item_r.action)
          ACT_PUSH_BACK: begin
            slot_off = PW'(cnt_r);
            ram_we   = !full;
          end
          ACT_PUSH_FRONT: begin
            slot_off = PW'(DEPTH - 1);
            ram_we   = !full;
          end
          ACT_POP_FRONT: slot_off = PW'(1);
          ACT_READ:      slot_off = PW'(item_r.index);
          default:       slot_off = '0;
        endcase
      end
      S_GROW_RD: slot_off = j_r;
      S_GROW_WR: begin
        slot_off = PW'(i_r);
        ram_we   = 1'b1;
      end
      S_RD_BACK: slot_off = PW'(cnt_r - 1'b1);
      default:   slot_off = '0;
    endcase
  end

  // sequencer: state, queue pointers and the result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r  <= in_item;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          status_r   <= ST_OK;
          read_hit_r <= 1'b0;
          state_r    <= S_RD_FRONT;
          case (item_r.action)
            ACT_PUSH_BACK: begin
              if (full) begin
                status_r <= ST_FULL;
              end else begin
                cnt_r <= cnt_r + 1'b1;
              end
            end
            ACT_POP_BACK: begin
              if (cnt_r != '0) begin
                cnt_r <= cnt_r - 1'b1;
              end
            end
            ACT_PUSH_FRONT: begin
              if (full) begin
                status_r <= ST_FULL;
              end else begin
                head_r <= slot;
                cnt_r  <= cnt_r + 1'b1;
              end
            end
            ACT_POP_FRONT: begin
              if (cnt_r != '0) begin
                head_r <= slot;
                cnt_r  <= cnt_r - 1'b1;
              end
            end
            ACT_READ: begin
              read_hit_r <= idx_ok;
              if (!idx_ok) begin
                status_r <= ST_RANGE;
              end
            end
            ACT_RESIZE: begin
              if (!resize_ok) begin
                status_r <= ST_RESIZE;
              end else if (nsz_c > cnt_r) begin
                i_r     <= cnt_r;
                j_r     <= '0;
                nsz_r   <= nsz_c;
                state_r <= S_GROW_RD;
              end else begin
                cnt_r <= nsz_c;
              end
            end
            default: begin
            end
          endcase
        end
        // copy entry j (i modulo old count) to new position i
        S_GROW_RD: begin
          if (i_r == nsz_r) begin
            cnt_r   <= nsz_r;
            state_r <= S_RD_FRONT;
          end else begin
            state_r <= S_GROW_WR;
          end
        end
        S_GROW_WR: begin
          i_r     <= i_r + 1'b1;
          j_r     <= (CW'(j_r) + 1'b1 == cnt_r) ? '0 : j_r + 1'b1;
          state_r <= S_GROW_RD;
        end
        // read data from the command cycle lands here
        S_RD_FRONT: begin
          read_r  <= read_hit_r ? word_out : 32'd0;
          state_r <= S_RD_BACK;
        end
        S_RD_BACK: begin
          front_r <= (cnt_r != '0) ? word_out : 32'd0;
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          out_item_r.front_value <= front_r;
          out_item_r.back_value  <= (cnt_r != '0) ? word_out : 32'd0;
          out_item_r.read_value  <= read_r;
          out_item_r.count       <= cnt_x[4:0];
          out_item_r.status      <= status_r;
          out_valid_r            <= 1'b1;
          state_r                <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // the result strobe lasts a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // an accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command accepted without going busy");

  // the count never exceeds the ring depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(DEPTH) >= cnt_r)
    else $error("entry count beyond depth");

  // an empty queue reports zero at both ends
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cnt_r == '0) |-> (out_item.front_value == 0 && out_item.back_value == 0))
    else $error("empty queue reported a non-zero end entry");

  // every grow write follows the read of its source entry
  a_grow_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GROW_WR) |-> ($past(state_r) == S_GROW_RD))
    else $error("grow write without a preceding read");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the double-ended queue against a cycle-free model of its contents.
// Commands go in through the start/busy handshake in bursts with random gaps.
// Every result strobe is compared field by field with the oldest prediction.
// Directed tests cover empty, full and refused cases; random traffic swings
// the fill level between empty and full.
// ----------------------------------------------------------------------------
module testbench;
  import deq_pkg::*;

  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 60;

  // action codes the block does not define; they must leave the queue alone
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  double_ended_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // shadow copy of the ring, head slot and occupancy
  logic signed [31:0] ring_shadow [DEPTH];
  logic [3:0]         head_shadow = '0;
  int                 held_shadow = 0;

  out_item_t pending_results [$];

  int fail_count   = 0;
  int cmds_sent    = 0;
  int results_seen = 0;
  int full_refused = 0;
  int range_errors = 0;
  int resize_refused = 0;
  int grow_resizes = 0;
  int peak_held    = 0;

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // queue model
  // --------------------------------------------------------------------------
  function automatic logic [3:0] ring_slot(input int logical);
    return head_shadow + logical[3:0];
  endfunction

  function automatic out_item_t deque_apply(input in_item_t cmd);
    out_item_t res;
    int        n;
    res = '0;
    res.status = ST_OK;
    case (cmd.action)
      ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
        if (held_shadow >= DEPTH) begin
          res.status = ST_FULL;
        end else if (cmd.action == ACT_PUSH_BACK) begin
          ring_shadow[ring_slot(held_shadow)] = cmd.value;
          held_shadow++;
        end else begin
          head_shadow = head_shadow - 4'd1;
          ring_shadow[head_shadow] = cmd.value;
          held_shadow++;
        end
      end
      ACT_POP_BACK: begin
        if (held_shadow > 0) held_shadow--;
      end
      ACT_POP_FRONT: begin
        if (held_shadow > 0) begin
          head_shadow = head_shadow + 4'd1;
          held_shadow--;
        end
      end
      ACT_READ: begin
        if (int'(cmd.index) >= held_shadow) res.status = ST_RANGE;
        else res.read_value = ring_shadow[ring_slot(int'(cmd.index))];
      end
      ACT_RESIZE: begin
        if (int'(cmd.new_size) > DEPTH ||
            (int'(cmd.new_size) > held_shadow && held_shadow == 0)) begin
          res.status = ST_RESIZE;
        end else begin
          // grow by repeating the old contents from the front
          for (n = held_shadow; n < int'(cmd.new_size); n++)
            ring_shadow[ring_slot(n)] = ring_shadow[ring_slot(n % held_shadow)];
          held_shadow = int'(cmd.new_size);
        end
      end
      default: ;
    endcase
    if (held_shadow > 0) begin
      res.front_value = ring_shadow[ring_slot(0)];
      res.back_value  = ring_shadow[ring_slot(held_shadow - 1)];
    end
    res.count = held_shadow[4:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // command driver
  // --------------------------------------------------------------------------
  // present one beat and hold it until taken; start stays high afterwards
  task automatic send_cmd(input in_item_t cmd);
    out_item_t res;
    in_item <= cmd;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    res = deque_apply(cmd);
    pending_results.insert(pending_results.size(), res);
    cmds_sent++;
    if (res.status == ST_FULL) full_refused++;
    if (res.status == ST_RANGE) range_errors++;
    if (res.status == ST_RESIZE) resize_refused++;
    if (held_shadow > peak_held) peak_held = held_shadow;
  endtask

  task automatic send_fields(input logic [2:0] action, input logic signed [31:0] value,
                             input logic [3:0] index, input logic [4:0] new_size);
    in_item_t cmd;
    cmd.action   = action;
    cmd.value    = value;
    cmd.index    = index;
    cmd.new_size = new_size;
    if (action == ACT_RESIZE && held_shadow > 0 && int'(new_size) > held_shadow &&
        int'(new_size) <= DEPTH)
      grow_resizes++;
    send_cmd(cmd);
  endtask

  // drop start and sit out a gap
  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // drop start and hold off until every outstanding result is back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding");
        fail_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_item.front_value !== want.front_value) begin
          $error("front_value: expected %0d, got %0d", want.front_value, out_item.front_value);
          fail_count++;
        end
        if (out_item.back_value !== want.back_value) begin
          $error("back_value: expected %0d, got %0d", want.back_value, out_item.back_value);
          fail_count++;
        end
        if (out_item.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_item.read_value);
          fail_count++;
        end
        if (out_item.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_item.count);
          fail_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: count cycles in which no beat moves either way
  // --------------------------------------------------------------------------
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("double_ended_queue: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // random command source
  // --------------------------------------------------------------------------
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  // filling leans on pushes, otherwise on pops
  task automatic send_random(input bit filling);
    int          roll;
    logic [2:0]  action;
    logic [3:0]  index;
    logic [4:0]  new_size;
    roll = $urandom_range(0, 99);
    if (roll < (filling ? 55 : 20))
      action = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    else if (roll < 75)
      action = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
    else if (roll < 92)
      action = ACT_READ;
    else if (roll < 98)
      action = ACT_RESIZE;
    else
      action = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
    if (held_shadow > 0 && $urandom_range(0, 3) != 0)
      index = 4'($urandom_range(0, held_shadow - 1));
    else
      index = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) new_size = 5'($urandom_range(DEPTH + 1, 31));
    else new_size = 5'($urandom_range(0, DEPTH));
    send_fields(action, pick_value(), index, new_size);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // empty queue: pops do nothing, grow refused, reads out of range
  task automatic test_empty_queue();
    send_fields(ACT_POP_BACK, 32'sd0, 4'd0, 5'd0);
    send_fields(ACT_POP_FRONT, 32'sd0, 4'd0, 5'd0);
    send_fields(ACT_RESIZE, 32'sd0, 4'd0, 5'd5);
    send_fields(ACT_RESIZE, 32'sd0, 4'd0, 5'd0);
    send_fields(ACT_READ, 32'sd0, 4'd0, 5'd0);
    idle_for(3);
  endtask

  // extreme words at both ends, reads inside and past the count, spare actions
  task automatic test_ends_and_reads();
    send_fields(ACT_PUSH_BACK, 32'sh7fffffff, 4'd0, 5'd0);
    send_fields(ACT_PUSH_FRONT, 32'sh80000000, 4'd0, 5'd0);
    send_fields(ACT_PUSH_BACK, -32'sd1, 4'd0, 5'd0);
    send_fields(ACT_READ, 32'sd0, 4'd0, 5'd0);
    send_fields(ACT_READ, 32'sd0, 4'd2, 5'd0);
    send_fields(ACT_READ, 32'sd0, 4'd3, 5'd0);
    send_fields(ACT_READ, 32'sd0, 4'd15, 5'd0);
    send_fields(ACT_SPARE_A, 32'sd0, 4'd0, 5'd0);
    send_fields(ACT_SPARE_B, -32'sd1, 4'd15, 5'd31);
    idle_for(2);
  endtask

  // grow to full, refuse pushes and oversize resizes, then shrink and empty
  task automatic test_full_and_resize();
    send_fields(ACT_RESIZE, 32'sd0, 4'd0, 5'd16);
    send_fields(ACT_PUSH_BACK, 32'sd5, 4'd0, 5'd0);
    send_fields(ACT_PUSH_FRONT, 32'sd6, 4'd0, 5'd0);
    send_fields(ACT_READ, 32'sd0, 4'd15, 5'd0);
    send_fields(ACT_RESIZE, 32'sd0, 4'd0, 5'd17);
    send_fields(ACT_RESIZE, 32'sd0, 4'd0, 5'd31);
    send_fields(ACT_RESIZE, 32'sd0, 4'd0, 5'd2);
    send_fields(ACT_POP_FRONT, 32'sd0, 4'd0, 5'd0);
    send_fields(ACT_POP_BACK, 32'sd0, 4'd0, 5'd0);
    send_fields(ACT_PUSH_FRONT, 32'sd0, 4'd0, 5'd0);
    send_fields(ACT_RESIZE, 32'sd0, 4'd0, 5'd0);
    drain_results();
  endtask

  // back-to-back commands with no gaps at all
  task automatic test_back_to_back(input int items);
    int k;
    for (k = 0; k < items; k++) send_random(k % 40 < 22);
    idle_for(1);
  endtask

  // bursts with random gaps; fill level swings, with an occasional full drain
  task automatic test_bursty_traffic(input int items);
    int  sent;
    int  burst;
    int  k;
    bit  filling;
    sent = 0;
    filling = 1'b1;
    while (sent < items) begin
      burst = $urandom_range(1, 24);
      for (k = 0; k < burst && sent < items; k++) begin
        send_random(filling);
        sent++;
        if (sent % 45 == 0) filling = !filling;
      end
      if ($urandom_range(0, 19) == 0) drain_results();
      else if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_ends_and_reads();
    test_full_and_resize();
    test_back_to_back(100);
    test_bursty_traffic(930);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fail_count++;
    end

    $display("ran %0d commands, %0d results checked, peak fill %0d of %0d",
             cmds_sent, results_seen, peak_held, DEPTH);
    $display("refusals: %0d full pushes, %0d reads out of range, %0d resizes; %0d grows",
             full_refused, range_errors, resize_refused, grow_resizes);
    if (fail_count == 0) begin
      $display("double_ended_queue: match");
    end else begin
      $display("double_ended_queue: mismatch");
    end
    $finish;
  end

endmodule
